// File: hw/rtl/etv_pkg.sv
// types, constants and constant tables shared by the synth voice
package etv_pkg;

  // fixed formats
  localparam int LEN_BITS      = 20;
  localparam int ENV_FRAC_BITS = 24;
  localparam int FREQ_BITS     = 23;
  localparam int PPH_BITS      = 20;
  localparam int TREM_BITS     = 13;
  localparam int ATK_BITS      = 16;
  localparam int SAMPLE_BITS   = 18;
  localparam int PHASE_BITS    = 32;

  // divider sizes
  localparam int DIV_Q_BITS    = 28;
  localparam int DIV_CNT_BITS  = 5;
  localparam logic [DIV_CNT_BITS-1:0] DIV_STEPS_DECAY  = DIV_CNT_BITS'(DIV_Q_BITS);
  localparam logic [DIV_CNT_BITS-1:0] DIV_STEPS_ATTACK = DIV_CNT_BITS'(ENV_FRAC_BITS);

  // exp2 iteration
  localparam int EXP_STEPS     = 24;
  localparam int EXP_K_BITS    = 5;
  localparam int ACC_BITS      = 31;
  localparam int C_BITS        = 30;

  // arithmetic constants
  localparam logic [DIV_Q_BITS-1:0] LOG2_1000_Q24 = 28'd167198116;
  localparam int TREM_DEPTH_Q16 = 13107;

  // reset values
  localparam logic [PPH_BITS-1:0]   PPH_RESET   = 20'd97392;
  localparam logic [TREM_BITS-1:0]  TREM_RESET  = 13'd1024;
  localparam logic [ATK_BITS-1:0]   ATK_RESET   = 16'd441;
  localparam logic [PHASE_BITS-1:0] STEP_RESET  = 32'd42852480;
  localparam logic [ENV_FRAC_BITS-1:0] DF_RESET = ENV_FRAC_BITS'(
    ((64'd1 << ENV_FRAC_BITS) * 64'd9999 + 64'd5000) / 64'd10000);

  // configuration register indexes
  localparam int CFG_ADDR_BITS = 4;
  localparam logic [1:0] REG_PPH  = 2'd0;
  localparam logic [1:0] REG_TREM = 2'd1;
  localparam logic [1:0] REG_ATK  = 2'd2;

  // shared multiplier operand selection
  typedef enum logic [3:0] {
    M_TSTEP = 4'd0,
    M_LSTEP = 4'd1,
    M_TSQ   = 4'd2,
    M_LSQ   = 4'd3,
    M_TREM  = 4'd4,
    M_DECAY = 4'd5,
    M_TENV  = 4'd6,
    M_AM    = 4'd7,
    M_EXP   = 4'd8
  } mul_sel_e;

  // product writeback destination
  typedef enum logic [3:0] {
    W_NONE  = 4'd0,
    W_TSTEP = 4'd1,
    W_PHASE = 4'd2,
    W_TSIN  = 4'd3,
    W_LSIN  = 4'd4,
    W_TREM  = 4'd5,
    W_DECAY = 4'd6,
    W_TENV  = 4'd7,
    W_EXP   = 4'd8
  } wb_sel_e;

  // controller to datapath commands
  typedef struct packed {
    mul_sel_e mul_sel;
    wb_sel_e  wb_sel;
    logic     cap_in;
    logic     load_trig;
    logic     div_decay;
    logic     div_attack;
    logic     env_from_div;
    logic     exp_init;
    logic     exp_step;
    logic     df_load;
    logic     left_dec;
    logic     res_load;
    logic     res_zero;
  } etv_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic is_trig;
    logic live;
    logic in_attack;
    logic div_busy;
    logic exp_last;
  } etv_stat_t;

  typedef logic [EXP_STEPS:0][C_BITS-1:0] exp_tab_t;

  // integer square root, bit by bit
  function automatic logic [63:0] isqrt64(input logic [63:0] v_in);
    logic [63:0] v;
    logic [63:0] r;
    logic [63:0] b;
    int i;
    v = v_in;
    r = '0;
    b = 64'h4000_0000_0000_0000;
    for (i = 0; i < 32; i++) begin
      if (b > v) b = b >> 2;
    end
    for (i = 0; i < 32; i++) begin
      if (b != 64'd0) begin
        if (v >= r + b) begin
          v = v - (r + b);
          r = (r >> 1) + b;
        end else begin
          r = r >> 1;
        end
        b = b >> 2;
      end
    end
    return r;
  endfunction

  // factors 2^(-2^-k) in Q30, built at elaboration
  function automatic exp_tab_t exp_table();
    exp_tab_t t;
    logic [63:0] c;
    int k;
    c = 64'd1 << 29;
    t[0] = C_BITS'(c);
    for (k = 1; k <= EXP_STEPS; k++) begin
      c = isqrt64(c << 30);
      t[k] = C_BITS'(c);
    end
    return t;
  endfunction

  localparam exp_tab_t EXP_TAB = exp_table();

  // magnitude of the phase scaled to 17 bits
  function automatic logic [16:0] xq_of(input logic [PHASE_BITS-1:0] ph);
    logic [PHASE_BITS-1:0] m;
    m = ph[PHASE_BITS-1] ? (PHASE_BITS'(0) - ph) : ph;
    return m[PHASE_BITS-1:15];
  endfunction

  // parabolic sine from phase and registered xq squared
  function automatic logic signed [SAMPLE_BITS-1:0] para_y(
    input logic [PHASE_BITS-1:0] ph, input logic [18:0] sq_sh);
    logic [18:0] mag;
    logic signed [SAMPLE_BITS-1:0] y;
    mag = {xq_of(ph), 2'b00} - sq_sh;
    y = {1'b0, mag[16:0]};
    return ph[PHASE_BITS-1] ? -y : y;
  endfunction

endpackage

// File: hw/rtl/etv_if.sv
// handshake channels for voice items and results
interface etv_in_if import etv_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic                 action;
  logic [FREQ_BITS-1:0] note_freq;
  logic [LEN_BITS-1:0]  note_length;

  modport source (output valid, action, note_freq, note_length, input ready);
  modport sink   (input valid, action, note_freq, note_length, output ready);
endinterface

interface etv_out_if import etv_pkg::*; ();
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample;
  logic                          active;

  modport source (output valid, sample, active, input ready);
  modport sink   (input valid, sample, active, output ready);
endinterface

// File: hw/rtl/etv_div.sv
// restoring divider, one quotient bit per cycle
module etv_div import etv_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  input  logic [LEN_BITS-1:0]     rem_i,
  input  logic [DIV_Q_BITS-1:0]   dvd_i,
  input  logic [LEN_BITS-1:0]     dvs_i,
  input  logic [DIV_CNT_BITS-1:0] steps_i,
  output logic                    busy_o,
  output logic [DIV_Q_BITS-1:0]   quo_o
);

  logic                    busy_q;
  logic [DIV_CNT_BITS-1:0] cnt_q;
  logic [LEN_BITS-1:0]     rem_q, rem_d, dvs_q;
  logic [DIV_Q_BITS-1:0]   dvd_q, quo_q;
  logic [LEN_BITS:0]       rem_sh;
  logic                    ge;

  // trial subtract
  always_comb begin
    rem_sh = {rem_q, dvd_q[DIV_Q_BITS-1]};
    ge     = rem_sh >= {1'b0, dvs_q};
    rem_d  = ge ? LEN_BITS'(rem_sh - {1'b0, dvs_q}) : rem_sh[LEN_BITS-1:0];
  end

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= steps_i;
    end else if (busy_q) begin
      cnt_q <= cnt_q - 1'b1;
      if (cnt_q == DIV_CNT_BITS'(1)) busy_q <= 1'b0;
    end
  end

  // operands and quotient
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= rem_i;
      dvd_q <= dvd_i;
      dvs_q <= dvs_i;
      quo_q <= '0;
    end else if (busy_q) begin
      rem_q <= rem_d;
      dvd_q <= {dvd_q[DIV_Q_BITS-2:0], 1'b0};
      quo_q <= {quo_q[DIV_Q_BITS-2:0], ge};
    end
  end

  assign busy_o = busy_q;
  assign quo_o  = quo_q;

endmodule

// File: hw/rtl/etv_datapath.sv
// voice datapath: shared multiplier, phases, envelope, decay factor
module etv_datapath import etv_pkg::*; (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  etv_cmd_t                      cmd_i,
  output etv_stat_t                     stat_o,
  input  logic                          action_i,
  input  logic [FREQ_BITS-1:0]          note_freq_i,
  input  logic [LEN_BITS-1:0]           note_length_i,
  input  logic [PPH_BITS-1:0]           pph_i,
  input  logic [TREM_BITS-1:0]          trem_i,
  input  logic [ATK_BITS-1:0]           atk_i,
  output logic signed [SAMPLE_BITS-1:0] sample_o,
  output logic                          active_o
);

  logic                          action_q;
  logic [FREQ_BITS-1:0]          freq_q;
  logic [LEN_BITS-1:0]           len_q;
  logic [PHASE_BITS-1:0]         tone_phase_q, lfo_phase_q, tone_step_q;
  logic [LEN_BITS-1:0]           total_q, left_q;
  logic [ENV_FRAC_BITS-1:0]      env_q, df_q;
  logic signed [SAMPLE_BITS-1:0] tone_y_q, lfo_y_q, am_q, s1_q;
  logic [ACC_BITS-1:0]           acc_q;
  logic [EXP_K_BITS-1:0]         k_q;
  logic signed [65:0]            p_q;
  logic signed [32:0]            mul_a, mul_b;
  logic signed [65:0]            p_sh16, p_shenv;
  logic signed [SAMPLE_BITS-1:0] sample_q;
  logic                          active_q;

  logic [ATK_BITS-1:0]           attack;
  logic [LEN_BITS-1:0]           elapsed, dec_len;
  logic                          div_start, div_busy;
  logic [LEN_BITS-1:0]           div_rem, div_dvs;
  logic [DIV_Q_BITS-1:0]         div_dvd, quo;
  logic [DIV_CNT_BITS-1:0]       div_steps;
  logic                          exp_bit;
  logic [3:0]                    ip;
  logic [ACC_BITS-1:0]           acc_sh;
  logic [ENV_FRAC_BITS:0]        df_raw;

  // effective attack and note position
  always_comb begin
    attack  = (atk_i == '0) ? ATK_BITS'(1) : atk_i;
    elapsed = total_q - left_q;
    dec_len = (len_q > LEN_BITS'(attack)) ? (len_q - LEN_BITS'(attack)) : LEN_BITS'(1);
  end

  // multiplier operand select
  always_comb begin
    case (cmd_i.mul_sel)
      M_TSTEP: begin mul_a = {10'b0, freq_q};        mul_b = {13'b0, pph_i}; end
      M_LSTEP: begin mul_a = {20'b0, trem_i};        mul_b = {13'b0, pph_i}; end
      M_TSQ:   begin mul_a = {16'b0, xq_of(tone_phase_q)};
                     mul_b = {16'b0, xq_of(tone_phase_q)}; end
      M_LSQ:   begin mul_a = {16'b0, xq_of(lfo_phase_q)};
                     mul_b = {16'b0, xq_of(lfo_phase_q)}; end
      M_TREM:  begin mul_a = 33'(lfo_y_q);           mul_b = 33'(TREM_DEPTH_Q16); end
      M_DECAY: begin mul_a = {9'b0, env_q};          mul_b = {9'b0, df_q}; end
      M_TENV:  begin mul_a = 33'(tone_y_q);          mul_b = {9'b0, env_q}; end
      M_AM:    begin mul_a = 33'(s1_q);              mul_b = 33'(am_q); end
      M_EXP:   begin mul_a = {2'b0, acc_q};          mul_b = {3'b0, EXP_TAB[k_q]}; end
      default: begin mul_a = '0;                     mul_b = '0; end
    endcase
  end

  // registered product
  always_ff @(posedge clk_i) begin
    p_q <= mul_a * mul_b;
  end

  assign p_sh16  = p_q >>> 16;
  assign p_shenv = p_q >>> ENV_FRAC_BITS;

  // attack and decay divider operands, exp2
  always_comb begin
    div_start = cmd_i.div_decay | cmd_i.div_attack;
    if (cmd_i.div_attack) begin
      div_rem   = elapsed;
      div_dvd   = '0;
      div_dvs   = LEN_BITS'(attack);
      div_steps = DIV_STEPS_ATTACK;
    end else begin
      div_rem   = '0;
      div_dvd   = LOG2_1000_Q24;
      div_dvs   = dec_len;
      div_steps = DIV_STEPS_DECAY;
    end
    exp_bit = quo[5'(EXP_STEPS) - k_q];
    ip      = quo[DIV_Q_BITS-1:ENV_FRAC_BITS];
    acc_sh  = acc_q >> ip;
    df_raw  = (ENV_FRAC_BITS+1)'(acc_sh >> (C_BITS - ENV_FRAC_BITS));
  end

  etv_div u_div (
    .clk_i,
    .rst_ni,
    .start_i (div_start),
    .rem_i   (div_rem),
    .dvd_i   (div_dvd),
    .dvs_i   (div_dvs),
    .steps_i (div_steps),
    .busy_o  (div_busy),
    .quo_o   (quo)
  );

  // captured item
  always_ff @(posedge clk_i) begin
    if (cmd_i.cap_in) begin
      action_q <= action_i;
      freq_q   <= note_freq_i;
      len_q    <= note_length_i;
    end
  end

  // voice state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tone_phase_q <= '0;
      lfo_phase_q  <= '0;
      tone_step_q  <= STEP_RESET;
      total_q      <= '0;
      left_q       <= '0;
      env_q        <= '0;
      df_q         <= DF_RESET;
    end else begin
      if (cmd_i.wb_sel == W_TSTEP) tone_step_q <= p_q[39:8];
      if (cmd_i.wb_sel == W_PHASE) begin
        tone_phase_q <= tone_phase_q + tone_step_q;
        lfo_phase_q  <= lfo_phase_q + p_q[39:8];
      end
      if (cmd_i.load_trig) begin
        total_q <= len_q;
        left_q  <= len_q;
        env_q   <= '0;
      end
      if (cmd_i.left_dec) left_q <= left_q - 1'b1;
      if (cmd_i.wb_sel == W_DECAY) env_q <= p_q[ENV_FRAC_BITS +: ENV_FRAC_BITS];
      if (cmd_i.env_from_div) env_q <= quo[ENV_FRAC_BITS-1:0];
      if (cmd_i.df_load) begin
        df_q <= df_raw[ENV_FRAC_BITS] ? {ENV_FRAC_BITS{1'b1}} : df_raw[ENV_FRAC_BITS-1:0];
      end
    end
  end

  // sample path and exp2 accumulator
  always_ff @(posedge clk_i) begin
    case (cmd_i.wb_sel)
      W_TSIN:  tone_y_q <= para_y(tone_phase_q, p_q[32:14]);
      W_LSIN:  lfo_y_q  <= para_y(lfo_phase_q, p_q[32:14]);
      W_TREM:  am_q     <= SAMPLE_BITS'(65536) + p_sh16[SAMPLE_BITS-1:0];
      W_TENV:  s1_q     <= p_shenv[SAMPLE_BITS-1:0];
      W_EXP:   if (exp_bit) acc_q <= p_q[C_BITS +: ACC_BITS];
      default: ;
    endcase
    if (cmd_i.exp_init) begin
      acc_q <= ACC_BITS'(1) << C_BITS;
      k_q   <= EXP_K_BITS'(1);
    end else if (cmd_i.exp_step) begin
      k_q <= k_q + 1'b1;
    end
  end

  // result register
  always_ff @(posedge clk_i) begin
    if (cmd_i.res_load) begin
      if (cmd_i.res_zero) begin
        sample_q <= '0;
        active_q <= 1'b0;
      end else begin
        sample_q <= p_sh16[SAMPLE_BITS-1:0];
        active_q <= 1'b1;
      end
    end
  end

  assign sample_o = sample_q;
  assign active_o = active_q;

  assign stat_o.is_trig   = action_q;
  assign stat_o.live      = left_q != '0;
  assign stat_o.in_attack = elapsed < LEN_BITS'(attack);
  assign stat_o.div_busy  = div_busy;
  assign stat_o.exp_last  = k_q == EXP_K_BITS'(EXP_STEPS);

endmodule

// File: hw/rtl/etv_ctrl.sv
// voice sequencer: steps the shared multiplier and divider per item
module etv_ctrl import etv_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  input  etv_stat_t stat_i,
  output etv_cmd_t  cmd_o
);

  typedef enum logic [20:0] {
    S_IDLE   = 21'h000001,
    S_TSTEP  = 21'h000002,
    S_TWB    = 21'h000004,
    S_TDIV   = 21'h000008,
    S_EMUL   = 21'h000010,
    S_EWB    = 21'h000020,
    S_EFIN   = 21'h000040,
    S_LSTEP  = 21'h000080,
    S_PHASE  = 21'h000100,
    S_TSQ    = 21'h000200,
    S_LSQ    = 21'h000400,
    S_LWB    = 21'h000800,
    S_TRM    = 21'h001000,
    S_ENV    = 21'h002000,
    S_EDIV   = 21'h004000,
    S_EDEC   = 21'h008000,
    S_TENV   = 21'h010000,
    S_TEWB   = 21'h020000,
    S_AM     = 21'h040000,
    S_OUT    = 21'h080000,
    S_SILENT = 21'h100000
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   slot_free;
  logic   in_xfer;

  assign slot_free = !out_valid_q || out_ready_i;
  assign in_xfer   = in_valid_i && (state_q == S_IDLE);

  // next state and commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    cmd_o.mul_sel = M_TSTEP;
    cmd_o.wb_sel  = W_NONE;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.cap_in = 1'b1;
          state_d = S_TSTEP;
        end
      end
      S_TSTEP: begin
        if (stat_i.is_trig) begin
          state_d = S_TWB;
        end else if (stat_i.live) begin
          state_d = S_LSTEP;
        end else begin
          state_d = S_SILENT;
        end
      end
      S_TWB: begin
        cmd_o.wb_sel    = W_TSTEP;
        cmd_o.load_trig = 1'b1;
        cmd_o.div_decay = 1'b1;
        state_d = S_TDIV;
      end
      S_TDIV: begin
        if (!stat_i.div_busy) begin
          cmd_o.exp_init = 1'b1;
          state_d = S_EMUL;
        end
      end
      S_EMUL: begin
        cmd_o.mul_sel = M_EXP;
        state_d = S_EWB;
      end
      S_EWB: begin
        cmd_o.mul_sel  = M_EXP;
        cmd_o.wb_sel   = W_EXP;
        cmd_o.exp_step = 1'b1;
        state_d = stat_i.exp_last ? S_EFIN : S_EMUL;
      end
      S_EFIN: begin
        cmd_o.df_load = 1'b1;
        state_d = S_IDLE;
      end
      S_LSTEP: begin
        cmd_o.mul_sel = M_LSTEP;
        state_d = S_PHASE;
      end
      S_PHASE: begin
        cmd_o.mul_sel = M_LSTEP;
        cmd_o.wb_sel  = W_PHASE;
        state_d = S_TSQ;
      end
      S_TSQ: begin
        cmd_o.mul_sel = M_TSQ;
        state_d = S_LSQ;
      end
      S_LSQ: begin
        cmd_o.mul_sel = M_LSQ;
        cmd_o.wb_sel  = W_TSIN;
        state_d = S_LWB;
      end
      S_LWB: begin
        cmd_o.mul_sel = M_LSQ;
        cmd_o.wb_sel  = W_LSIN;
        state_d = S_TRM;
      end
      S_TRM: begin
        cmd_o.mul_sel = M_TREM;
        state_d = S_ENV;
      end
      S_ENV: begin
        cmd_o.mul_sel = M_DECAY;
        cmd_o.wb_sel  = W_TREM;
        if (stat_i.in_attack) begin
          cmd_o.div_attack = 1'b1;
          state_d = S_EDIV;
        end else begin
          state_d = S_EDEC;
        end
      end
      S_EDIV: begin
        if (!stat_i.div_busy) begin
          cmd_o.env_from_div = 1'b1;
          state_d = S_TENV;
        end
      end
      S_EDEC: begin
        cmd_o.wb_sel = W_DECAY;
        state_d = S_TENV;
      end
      S_TENV: begin
        cmd_o.mul_sel  = M_TENV;
        cmd_o.left_dec = 1'b1;
        state_d = S_TEWB;
      end
      S_TEWB: begin
        cmd_o.mul_sel = M_TENV;
        cmd_o.wb_sel  = W_TENV;
        state_d = S_AM;
      end
      S_AM: begin
        cmd_o.mul_sel = M_AM;
        state_d = S_OUT;
      end
      S_OUT: begin
        cmd_o.mul_sel = M_AM;
        if (slot_free) begin
          cmd_o.res_load = 1'b1;
          state_d = S_IDLE;
        end
      end
      S_SILENT: begin
        if (slot_free) begin
          cmd_o.res_load = 1'b1;
          cmd_o.res_zero = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // result slot occupancy
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) out_valid_d = 1'b0;
    if (cmd_o.res_load) out_valid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = (state_q == S_IDLE) && (in_xfer || !in_valid_i);
  assign out_valid_o = out_valid_q;

endmodule

// File: hw/rtl/enveloped_tone_voice_top.sv
// Single synth voice: parabolic sine tone with attack/decay envelope and tremolo.
// Input channel item_i carries one item per transfer: action 0 is a sample
// tick, action 1 triggers a note with note_freq (Q15.8 Hz) and note_length.
// A tick yields one result on result_o (Q.16 sample, active flag); a trigger
// yields none. Configuration is written over the APB port at 0x0, 0x4, 0x8.
// Items are processed one at a time by a sequencer around one shared
// multiplier and a one-bit-per-cycle divider.
// A sounding tick in decay runs the multiply steps only; a sounding tick in
// attack adds a 24-bit envelope division. A silent tick loads a zero result.
// A trigger runs a 28-bit division, then 24 exp2 multiply steps. The next
// item is taken once the sequencer is back in idle.
// One result register decouples the output: a finished result waits there
// while the next item is taken; the sequencer only waits when a new result
// is ready and the register is still held by a stalled receiver.
// Reset clears phases, envelope and note counters, loads the 440 Hz step,
// the default decay factor and the default configuration registers.
module enveloped_tone_voice_top import etv_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  etv_in_if.sink                   item_i,
  etv_out_if.source                result_o,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [CFG_ADDR_BITS-1:0] paddr,
  input  logic [31:0]              pwdata,
  output logic [31:0]              prdata,
  output logic                     pready
);

  logic [PPH_BITS-1:0]  pph_q;
  logic [TREM_BITS-1:0] trem_q;
  logic [ATK_BITS-1:0]  atk_q;
  logic                 cfg_wr;
  etv_cmd_t             cmd;
  etv_stat_t            stat;

  // configuration registers
  assign cfg_wr = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pph_q  <= PPH_RESET;
      trem_q <= TREM_RESET;
      atk_q  <= ATK_RESET;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        REG_PPH:  pph_q  <= pwdata[PPH_BITS-1:0];
        REG_TREM: trem_q <= pwdata[TREM_BITS-1:0];
        REG_ATK:  atk_q  <= pwdata[ATK_BITS-1:0];
        default:  ;
      endcase
    end
  end

  // register readback
  always_comb begin
    case (paddr[3:2])
      REG_PPH:  prdata = 32'(pph_q);
      REG_TREM: prdata = 32'(trem_q);
      REG_ATK:  prdata = 32'(atk_q);
      default:  prdata = '0;
    endcase
  end

  etv_ctrl u_ctrl (
    .clk_i,
    .rst_ni,
    .in_valid_i  (item_i.valid),
    .in_ready_o  (item_i.ready),
    .out_valid_o (result_o.valid),
    .out_ready_i (result_o.ready),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  etv_datapath u_datapath (
    .clk_i,
    .rst_ni,
    .cmd_i         (cmd),
    .stat_o        (stat),
    .action_i      (item_i.action),
    .note_freq_i   (item_i.note_freq),
    .note_length_i (item_i.note_length),
    .pph_i         (pph_q),
    .trem_i        (trem_q),
    .atk_i         (atk_q),
    .sample_o      (result_o.sample),
    .active_o      (result_o.active)
  );

endmodule

// File: tb/enveloped_tone_voice_top_tb.sv
// testbench for the synth voice: random and directed items checked against a local predictor
module enveloped_tone_voice_top_tb import etv_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] REG_UNUSED = 2'd3;
  localparam int SETTLE_CYCLES = 120;
  localparam int HOLD_CYCLES = 400;
  localparam bit ACT_TICK = 1'b0;
  localparam bit ACT_TRIG = 1'b1;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] sample;
    logic                          active;
  } voice_out_t;

  logic clk_i;
  logic rst_ni;
  logic psel;
  logic penable;
  logic pwrite;
  logic [CFG_ADDR_BITS-1:0] paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic pready;

  etv_in_if  item_if ();
  etv_out_if res_if ();

  enveloped_tone_voice_top dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .item_i   (item_if.sink),
    .result_o (res_if.source),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  // clock
  always begin
    clk_i = 1'b0;
    #6;
    clk_i = 1'b1;
    #6;
  end

  // voice model state
  logic [PPH_BITS-1:0]      m_pph;
  logic [TREM_BITS-1:0]     m_trem;
  logic [ATK_BITS-1:0]      m_atk;
  logic [PHASE_BITS-1:0]    m_tone_ph;
  logic [PHASE_BITS-1:0]    m_lfo_ph;
  logic [PHASE_BITS-1:0]    m_tone_step;
  logic [LEN_BITS-1:0]      m_total;
  logic [LEN_BITS-1:0]      m_left;
  logic [ENV_FRAC_BITS-1:0] m_env;
  logic [ENV_FRAC_BITS-1:0] m_decay;
  longint unsigned          root_tab [0:24];

  voice_out_t pending_samples [$];
  int  error_count;
  bit  sender_gaps;
  bit  receiver_gaps;
  bit  hold_request;

  function automatic longint unsigned int_sqrt(input longint unsigned v_in);
    longint unsigned v, r, b;
    v = v_in;
    r = 0;
    b = 64'h4000_0000_0000_0000;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic logic [ENV_FRAC_BITS-1:0] decay_from_span(input longint unsigned span);
    longint unsigned e, whole, acc, r;
    e = 64'd167198116 / span;
    whole = e >> 24;
    acc = 64'd1 << 30;
    for (int k = 1; k <= 24; k++) begin
      if ((e >> (24 - k)) & 1) acc = (acc * root_tab[k]) >> 30;
    end
    acc = (whole < 63) ? (acc >> whole) : 0;
    r = acc >> (30 - ENV_FRAC_BITS);
    if (r >= (64'd1 << ENV_FRAC_BITS)) r = (64'd1 << ENV_FRAC_BITS) - 1;
    return r[ENV_FRAC_BITS-1:0];
  endfunction

  function automatic longint parabola(input logic [31:0] p);
    longint unsigned mag, xq;
    longint y;
    mag = p[31] ? longint'(33'h1_0000_0000 - {1'b0, p}) : longint'(p);
    xq = mag >> 15;
    y = longint'(4 * xq) - longint'((4 * xq * xq) >> 16);
    return p[31] ? -y : y;
  endfunction

  task automatic model_reset();
    longint unsigned c;
    m_pph = PPH_RESET;
    m_trem = TREM_RESET;
    m_atk = ATK_RESET;
    m_tone_ph = '0;
    m_lfo_ph = '0;
    m_tone_step = 32'd42852480;
    m_total = '0;
    m_left = '0;
    m_env = '0;
    m_decay = ENV_FRAC_BITS'(((64'd1 << ENV_FRAC_BITS) * 9999 + 5000) / 10000);
    c = 64'd1 << 29;
    root_tab[0] = c;
    for (int k = 1; k <= 24; k++) begin
      c = int_sqrt(c << 30);
      root_tab[k] = c;
    end
  endtask

  // advance the voice by one accepted item, queueing the sample it yields
  task automatic model_item(input bit act, input logic [FREQ_BITS-1:0] freq,
                            input logic [LEN_BITS-1:0] len);
    longint unsigned atk, elapsed, span, lstep;
    longint tone, lfo, am, s;
    voice_out_t o;
    atk = (m_atk == 0) ? 1 : m_atk;
    if (act == ACT_TRIG) begin
      span = (len > atk) ? (len - atk) : 1;
      m_tone_step = 32'((longint'(freq) * m_pph) >> 8);
      m_total = len;
      m_left = len;
      m_env = '0;
      m_decay = decay_from_span(span);
      return;
    end
    if (m_left == 0) begin
      o.sample = '0;
      o.active = 1'b0;
      pending_samples.push_back(o);
      return;
    end
    elapsed = m_total - m_left;
    if (elapsed < atk) m_env = ENV_FRAC_BITS'((elapsed << ENV_FRAC_BITS) / atk);
    else m_env = ENV_FRAC_BITS'((longint'(m_env) * m_decay) >> ENV_FRAC_BITS);
    m_left = m_left - 1'b1;
    lstep = (longint'(m_trem) * m_pph) >> 8;
    m_tone_ph = m_tone_ph + m_tone_step;
    m_lfo_ph = m_lfo_ph + 32'(lstep);
    tone = parabola(m_tone_ph);
    lfo = parabola(m_lfo_ph);
    am = 65536 + ((lfo * 13107) >>> 16);
    s = (tone * longint'(m_env)) >>> ENV_FRAC_BITS;
    s = (s * am) >>> 16;
    o.sample = SAMPLE_BITS'(s);
    o.active = 1'b1;
    pending_samples.push_back(o);
  endtask

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("error %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    error_count++;
  endtask

  // sample checking on each result transfer
  always @(posedge clk_i) begin
    voice_out_t want;
    if (rst_ni && res_if.valid && res_if.ready) begin
      if (pending_samples.size() == 0) begin
        report_mismatch("unexpected sample", res_if.sample, 0);
      end else begin
        want = pending_samples.pop_front();
        if (res_if.sample !== want.sample)
          report_mismatch("sample", res_if.sample, want.sample);
        if (res_if.active !== want.active)
          report_mismatch("active", res_if.active, want.active);
      end
    end
  end

  // receiver: random stalls, plus one long hold-off on request
  int stall_left;
  int hold_left;
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      stall_left <= 0;
      hold_left <= 0;
      res_if.ready <= 1'b0;
    end else if (hold_request && hold_left == 0) begin
      hold_left <= HOLD_CYCLES;
      stall_left <= 0;
      res_if.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      res_if.ready <= (hold_left == 1);
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      res_if.ready <= (stall_left == 1);
    end else if (res_if.valid && res_if.ready && receiver_gaps) begin
      stall_left <= $urandom_range(0, 15);
      res_if.ready <= 1'b0;
    end else begin
      res_if.ready <= 1'b1;
    end
  end

  // one item transfer; valid stays high for back-to-back items
  task automatic send_item(input bit act, input logic [FREQ_BITS-1:0] freq,
                           input logic [LEN_BITS-1:0] len);
    int gap;
    gap = sender_gaps ? $urandom_range(0, 15) : 0;
    if (gap > 0) begin
      item_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    item_if.valid <= 1'b1;
    item_if.action <= act;
    item_if.note_freq <= freq;
    item_if.note_length <= len;
    do @(posedge clk_i); while (!item_if.ready);
    model_item(act, freq, len);
  endtask

  task automatic wait_idle();
    item_if.valid <= 1'b0;
    while (pending_samples.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_PPH:  m_pph = val[PPH_BITS-1:0];
      REG_TREM: m_trem = val[TREM_BITS-1:0];
      REG_ATK:  m_atk = val[ATK_BITS-1:0];
      default: ;
    endcase
  endtask

  task automatic set_voice(input logic [31:0] pph, input logic [31:0] trem,
                           input logic [31:0] atk);
    wait_idle();
    write_reg(REG_PPH, pph);
    write_reg(REG_TREM, trem);
    write_reg(REG_ATK, atk);
  endtask

  task automatic ticks(input int n);
    repeat (n) send_item(ACT_TICK, FREQ_BITS'($urandom), LEN_BITS'($urandom));
  endtask

  // reset defaults, silence, field extremes and the named corner cases
  task automatic test_directed();
    ticks(2);
    send_item(ACT_TRIG, 23'd112640, 20'd460);
    ticks(4);
    send_item(ACT_TRIG, 23'd5644800, 20'd0);
    ticks(2);
    set_voice(32'd1048575, 32'd5120, 32'd0);
    write_reg(REG_UNUSED, 32'hFFFF_FFFF);
    send_item(ACT_TRIG, 23'h7FFFFF, 20'hFFFFF);
    ticks(3);
    send_item(ACT_TRIG, 23'd0, 20'd1);
    ticks(2);
    set_voice(32'd0, 32'd0, 32'd65535);
    send_item(ACT_TRIG, 23'd300000, 20'd3);
    ticks(3);
    set_voice(32'd97392, 32'd1024, 32'd3);
    send_item(ACT_TRIG, 23'd60000, 20'd4);
    ticks(2);
    send_item(ACT_TRIG, 23'd4000000, 20'd10);
    ticks(3);
  endtask

  // well-formed notes with random content, some retriggers and noise
  task automatic test_random_notes(input int n_items);
    int sent;
    int n;
    logic [LEN_BITS-1:0] len;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(0, 9) == 0) len = LEN_BITS'($urandom);
      else len = LEN_BITS'($urandom_range(0, 40));
      send_item(ACT_TRIG, FREQ_BITS'($urandom_range(0, 5644800)), len);
      n = $urandom_range(0, 30);
      ticks(n);
      sent += n + 1;
    end
  endtask

  // several settings, extremes among them
  task automatic test_config_sweep();
    for (int i = 0; i < 6; i++) begin
      set_voice($urandom_range(0, 1048575), $urandom_range(0, 5120), $urandom_range(1, 12));
      sender_gaps = i[0];
      receiver_gaps = i[1];
      test_random_notes(120);
    end
    sender_gaps = 1'b1;
    receiver_gaps = 1'b1;
    set_voice(32'd1, 32'd1, 32'd1);
    test_random_notes(60);
    set_voice(32'd1048575, 32'd5120, 32'd2);
    test_random_notes(200);
  endtask

  // receiver holds off while items keep coming
  task automatic test_backpressure();
    sender_gaps = 1'b0;
    hold_request = 1'b1;
    do @(posedge clk_i); while (hold_left == 0);
    hold_request = 1'b0;
    send_item(ACT_TRIG, 23'd112640, 20'd100);
    ticks(40);
    sender_gaps = 1'b1;
  endtask

  initial begin
    rst_ni = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    item_if.valid = 1'b0;
    item_if.action = 1'b0;
    item_if.note_freq = '0;
    item_if.note_length = '0;
    error_count = 0;
    sender_gaps = 1'b1;
    receiver_gaps = 1'b1;
    hold_request = 1'b0;
    model_reset();
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_backpressure();
    set_voice(32'd97392, 32'd1024, 32'd5);
    test_random_notes(150);
    test_config_sweep();
    wait_idle();
    if (error_count == 0) begin
      $display("enveloped_tone_voice_top: match");
    end else begin
      $display("enveloped_tone_voice_top: mismatch");
    end
    $finish;
  end

  // watchdog
  initial begin
    #30ms;
    $display("enveloped_tone_voice_top: mismatch");
    $finish;
  end

endmodule

// File: sim.f
hw/rtl/etv_pkg.sv
hw/rtl/etv_if.sv
hw/rtl/etv_div.sv
hw/rtl/etv_datapath.sv
hw/rtl/etv_ctrl.sv
hw/rtl/enveloped_tone_voice_top.sv
tb/enveloped_tone_voice_top_tb.sv
